/* hdl/kmds_pkg.sv */
// ----------------------------------------------------------------------------
// kmds_pkg
// Shared types and constants for the key matrix debounce scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package kmds_pkg;

  localparam int unsigned LevelBits    = 3;
  localparam int unsigned RowFieldW    = 2;
  localparam int unsigned ColFieldW    = 2;
  localparam int unsigned StampW       = 32;
  localparam int unsigned DebounceW    = 16;
  localparam logic [DebounceW-1:0] DebounceReset = 16'd20;

  typedef logic [RowFieldW-1:0] row_field_t;
  typedef logic [ColFieldW-1:0] col_field_t;

  typedef struct packed {
    row_field_t            row_index;
    logic [LevelBits-1:0]  column_levels;
    logic [StampW-1:0]     now_ms;
  } in_item_t;

  typedef struct packed {
    logic                  is_press;
    row_field_t            key_row;
    col_field_t            key_column;
    logic [StampW-1:0]     event_time;
    logic                  last_event;
  } out_item_t;

endpackage

`default_nettype wire

/* hdl/kmds_fifo.sv */
// ----------------------------------------------------------------------------
// kmds_fifo
// Two-entry queue between the sampling front and the event back.
// ----------------------------------------------------------------------------
`default_nettype none

module kmds_fifo #(
  parameter type T = logic
) (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   push_i,
  input  wire T push_data_i,
  output logic  full_o,
  input  wire   pop_i,
  output T      head_o,
  output logic  empty_o
);

  T           mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/kmds_front.sv */
// ----------------------------------------------------------------------------
// kmds_front
// Takes row samples, updates per-key debounce state, queues event masks.
// ----------------------------------------------------------------------------
`default_nettype none

module kmds_front #(
  parameter int unsigned ROWS      = 4,
  parameter int unsigned COLS      = 3,
  parameter int unsigned TIME_BITS = 32
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_we_i,
  input  wire  [kmds_pkg::DebounceW-1:0]        cfg_wdata_i,
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire  kmds_pkg::in_item_t              in_data_i,
  output logic                                  push_o,
  output logic [kmds_pkg::RowFieldW-1:0]        push_row_o,
  output logic [COLS-1:0]                       push_fire_o,
  output logic [COLS-1:0]                       push_press_o,
  output logic [TIME_BITS-1:0]                  push_time_o,
  input  wire                                   full_i
);

  localparam int unsigned RowIdxW = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [kmds_pkg::DebounceW-1:0] debounce_q;
  logic                           raw_q    [ROWS][COLS];
  logic                           stable_q [ROWS][COLS];
  logic [TIME_BITS-1:0]           time_q   [ROWS][COLS];

  logic [COLS+kmds_pkg::LevelBits-1:0] levels_ext;
  logic [RowIdxW-1:0]                  row_sel;
  logic                                row_ok;
  logic                                accept;
  logic [TIME_BITS-1:0]                now_t;
  logic [TIME_BITS-1:0]                limit;
  logic [COLS-1:0]                     press_n;
  logic [COLS-1:0]                     fire;
  logic [TIME_BITS-1:0]                time_n   [COLS];
  logic [TIME_BITS-1:0]                elapsed  [COLS];

  always_comb begin
    levels_ext = {{COLS{1'b1}}, in_data_i.column_levels};
    row_ok     = ({30'd0, in_data_i.row_index} < 32'(ROWS));
    row_sel    = RowIdxW'(in_data_i.row_index);
    now_t      = in_data_i.now_ms[TIME_BITS-1:0];
    limit      = TIME_BITS'(debounce_q);
    for (int c = 0; c < COLS; c++) begin
      press_n[c] = ~levels_ext[c];
      time_n[c]  = (press_n[c] != raw_q[row_sel][c]) ? now_t : time_q[row_sel][c];
      elapsed[c] = now_t - time_n[c];
      fire[c]    = (elapsed[c] >= limit) && (stable_q[row_sel][c] != press_n[c]);
    end
  end

  assign in_stall_o   = full_i;
  assign accept       = in_valid_i && !full_i;
  assign push_o       = accept && row_ok && (|fire);
  assign push_row_o   = in_data_i.row_index;
  assign push_fire_o  = fire;
  assign push_press_o = press_n;
  assign push_time_o  = now_t;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= kmds_pkg::DebounceReset;
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < COLS; c++) begin
          raw_q[r][c]    <= 1'b0;
          stable_q[r][c] <= 1'b0;
          time_q[r][c]   <= '0;
        end
      end
    end else begin
      if (cfg_we_i) begin
        debounce_q <= cfg_wdata_i;
      end
      if (accept && row_ok) begin
        for (int c = 0; c < COLS; c++) begin
          raw_q[row_sel][c]  <= press_n[c];
          time_q[row_sel][c] <= time_n[c];
          if (fire[c]) begin
            stable_q[row_sel][c] <= press_n[c];
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/kmds_back.sv */
// ----------------------------------------------------------------------------
// kmds_back
// Walks the queued event mask of one row and emits one event per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module kmds_back #(
  parameter int unsigned COLS      = 3,
  parameter int unsigned TIME_BITS = 32
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             empty_i,
  input  wire  [kmds_pkg::RowFieldW-1:0]  head_row_i,
  input  wire  [COLS-1:0]                 head_fire_i,
  input  wire  [COLS-1:0]                 head_press_i,
  input  wire  [TIME_BITS-1:0]            head_time_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output kmds_pkg::out_item_t             out_data_o
);

  localparam int unsigned ColIdxW = (COLS > 1) ? $clog2(COLS) : 1;

  logic [COLS-1:0]                mask_q, mask_d;
  logic [COLS-1:0]                press_q;
  logic [kmds_pkg::RowFieldW-1:0] row_q;
  logic [TIME_BITS-1:0]           time_q;
  logic                           out_valid_q, out_valid_d;
  kmds_pkg::out_item_t            out_q;

  logic                           slot_free;
  logic                           emit;
  logic [COLS-1:0]                low_bit;
  logic [COLS-1:0]                mask_after;
  logic [ColIdxW-1:0]             sel;

  always_comb begin
    low_bit = mask_q & (~mask_q + 1'b1);
    sel     = '0;
    for (int c = 0; c < COLS; c++) begin
      if (low_bit[c]) begin
        sel = ColIdxW'(c);
      end
    end
    slot_free   = !out_valid_q || !out_stall_i;
    emit        = slot_free && (mask_q != '0);
    mask_after  = emit ? (mask_q & ~low_bit) : mask_q;
    pop_o       = !empty_i && (mask_after == '0);
    mask_d      = pop_o ? head_fire_i : mask_after;
    out_valid_d = emit ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      press_q <= head_press_i;
      row_q   <= head_row_i;
      time_q  <= head_time_i;
    end
    if (emit) begin
      out_q.is_press   <= press_q[sel];
      out_q.key_row    <= row_q;
      out_q.key_column <= kmds_pkg::col_field_t'(sel);
      out_q.event_time <= kmds_pkg::StampW'(time_q);
      out_q.last_event <= (mask_after == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* hdl/key_matrix_debounce_scanner_top.sv */
// ----------------------------------------------------------------------------
// key_matrix_debounce_scanner_top
// Key matrix row scanner with per-key debounce and press/release events.
//
// Input channel: one sampled row per transaction (row index, column levels,
// millisecond stamp). The sample is taken in the cycle it is accepted; the
// per-key raw level, stable level and change time of that row update then.
// Output channel: one press or release event per transaction, in ascending
// column order, last_event set on the final event of a sample.
// The first event of a sample passes through the queue, the walker's mask
// register and the output register. The event walker emits one event per
// cycle from a two-entry queue while the output is not stalled.
// Samples causing no event, or with an out-of-range row, are not queued,
// but every sample waits while the queue is full.
// A stalled output holds its event; the queue keeps taking samples until
// full, then the input is stalled.
// Reset clears all key state to not pressed, change times to zero, and the
// debounce setting to 20 ms. cfg_we_i writes the debounce setting.
// ----------------------------------------------------------------------------
`default_nettype none

module key_matrix_debounce_scanner_top #(
  parameter int unsigned ROWS      = 4,
  parameter int unsigned COLS      = 3,
  parameter int unsigned TIME_BITS = 32
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [kmds_pkg::DebounceW-1:0]   cfg_wdata_i,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  kmds_pkg::in_item_t         in_data_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output kmds_pkg::out_item_t              out_data_o
);

  typedef struct packed {
    logic [kmds_pkg::RowFieldW-1:0] row;
    logic [COLS-1:0]                fire;
    logic [COLS-1:0]                press;
    logic [TIME_BITS-1:0]           stamp;
  } entry_t;

  entry_t push_entry;
  entry_t head_entry;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;

  kmds_front #(
    .ROWS      (ROWS),
    .COLS      (COLS),
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .push_o       (push),
    .push_row_o   (push_entry.row),
    .push_fire_o  (push_entry.fire),
    .push_press_o (push_entry.press),
    .push_time_o  (push_entry.stamp),
    .full_i       (full)
  );

  kmds_fifo #(
    .T (entry_t)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head_entry),
    .empty_o     (empty)
  );

  kmds_back #(
    .COLS      (COLS),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .head_row_i   (head_entry.row),
    .head_fire_i  (head_entry.fire),
    .head_press_i (head_entry.press),
    .head_time_i  (head_entry.stamp),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire
